// ===== rtl/core/qs_pkg.sv =====
// ----------------------------------------------------------------------------
// qs_pkg
// Shared types and constants for the quicksort engine: controller states,
// datapath operations and the status group the datapath returns.
// ----------------------------------------------------------------------------
`default_nettype none

package qs_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_POP,
    ST_RANGE,
    ST_PIVOT,
    ST_CMP,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_FIN,
    ST_FIX_A,
    ST_FIX_B,
    ST_PUSH_L,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_START,
    OP_POP,
    OP_RANGE,
    OP_PIVOT,
    OP_CMP,
    OP_SWAP_A,
    OP_SWAP_B,
    OP_FIN,
    OP_FIX_A,
    OP_FIX_B,
    OP_PUSH_L,
    OP_EMIT_INIT,
    OP_EMIT_OUT
  } dp_op_t;

  typedef struct packed {
    logic top_zero;     // range stack empty
    logic range_empty;  // popped range has fewer than two elements
    logic is_less;      // element read is below the pivot
    logic k_at_hi;      // scan index reached the end of the range
    logic out_free;     // output register can take a beat
    logic emit_last;    // element being emitted is the final one
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/quicksort_engine.sv =====
// ----------------------------------------------------------------------------
// quicksort_engine
// Collects signed values, sorts them ascending with an in-place quicksort
// and streams the sorted set out with a last flag and a dropped-input flag.
// ----------------------------------------------------------------------------
// Loading takes one beat per cycle; values beyond DEPTH are dropped and mark
// every result of the set with overflow. The beat with in_last_item starts
// the sort, and no input is taken until the final result is in the output
// register. Sorting works on an element memory with one read and one write
// port: each range is popped, its first element taken as pivot, every further
// element compared against it and each smaller one exchanged with the entry at
// the split point in two writes; the pivot is then put in place and the two
// subranges pushed. Emission fetches each value before it enters the output
// register; an output stall during the fetch costs nothing since the output
// register holds one beat while the next value is fetched.
`default_nettype none

module quicksort_engine #(
  parameter int unsigned DEPTH = qs_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_last_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_sorted_value,
  output logic                    out_last_out,
  output logic                    out_overflow
);

  qs_pkg::dp_op_t     op;
  qs_pkg::dp_status_t status;

  qs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .in_ready     (in_ready),
    .status       (status),
    .op           (op)
  );

  qs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .status           (status),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

endmodule

`default_nettype wire

// ===== rtl/core/qs_datapath.sv =====
// ----------------------------------------------------------------------------
// qs_datapath
// Element store, range stack, partition registers and the output register.
// Carries out one operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_datapath #(
  parameter int unsigned DEPTH = qs_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire qs_pkg::dp_op_t     op,
  output qs_pkg::dp_status_t      status,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_sorted_value,
  output logic                    out_last_out,
  output logic                    out_overflow
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // memories
  logic signed [31:0] elem_mem [DEPTH];
  logic [2*IW-1:0]    stk_mem [DEPTH];
  logic signed [31:0] mem_rd_r;
  logic [2*IW-1:0]    stk_rd_r;

  logic               mem_we;
  logic [IW-1:0]      mem_wa;
  logic signed [31:0] mem_wd;
  logic [IW-1:0]      mem_ra;
  logic               stk_we;
  logic [IW-1:0]      stk_wa;
  logic [2*IW-1:0]    stk_wd;
  logic [IW-1:0]      stk_ra;

  // control and working registers
  logic [CW-1:0]      count_r, count_nxt;
  logic               dropped_r, dropped_nxt;
  logic [CW-1:0]      top_r, top_nxt;
  logic [IW-1:0]      lo_r, lo_nxt;
  logic [IW-1:0]      hi_r, hi_nxt;
  logic [IW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      split_r, split_nxt;
  logic signed [31:0] pivot_r, pivot_nxt;
  logic signed [31:0] tmp_r, tmp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic [IW-1:0]      pop_lo;
  logic [IW-1:0]      pop_hi;
  logic [IW-1:0]      k_inc;
  logic               push_r_ok;
  logic               push_l_ok;

  assign pop_lo = stk_rd_r[2*IW-1:IW];
  assign pop_hi = stk_rd_r[IW-1:0];
  assign k_inc  = k_r + IW'(1);
  assign stk_ra = IW'(top_r - ONE_C);

  assign push_r_ok = ((split_r + ONE_C) < CW'(hi_r)) && (top_r < DEPTH_C);
  assign push_l_ok = (split_r > (CW'(lo_r) + ONE_C)) && (top_r < DEPTH_C);

  assign status.top_zero    = (top_r == '0);
  assign status.range_empty = (pop_lo >= pop_hi);
  assign status.is_less     = (mem_rd_r < pivot_r);
  assign status.k_at_hi     = (k_r == hi_r);
  assign status.out_free    = !out_valid_r || out_ready;
  assign status.emit_last   = ((CW'(k_r) + ONE_C) == count_r);

  always_comb begin
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    top_nxt       = top_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    split_nxt     = split_r;
    pivot_nxt     = pivot_r;
    tmp_nxt       = tmp_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_wa        = k_r;
    mem_wd        = mem_rd_r;
    mem_ra        = k_r;
    stk_we        = 1'b0;
    stk_wa        = IW'(top_r);
    stk_wd        = {lo_r, hi_r};

    unique case (op)
      qs_pkg::OP_IDLE: begin
      end
      qs_pkg::OP_LOAD: begin
        if (count_r < DEPTH_C) begin
          mem_we    = 1'b1;
          mem_wa    = IW'(count_r);
          mem_wd    = in_value;
          count_nxt = count_r + ONE_C;
        end else begin
          dropped_nxt = 1'b1;
        end
      end
      qs_pkg::OP_START: begin
        stk_we  = 1'b1;
        stk_wa  = '0;
        stk_wd  = {IW'(0), IW'(count_r - ONE_C)};
        top_nxt = (count_r > ONE_C) ? ONE_C : '0;
      end
      qs_pkg::OP_POP: begin
        top_nxt = top_r - ONE_C;
      end
      qs_pkg::OP_RANGE: begin
        lo_nxt = pop_lo;
        hi_nxt = pop_hi;
        mem_ra = pop_lo;
      end
      qs_pkg::OP_PIVOT: begin
        pivot_nxt = mem_rd_r;
        k_nxt     = lo_r + IW'(1);
        split_nxt = CW'(lo_r) + ONE_C;
        mem_ra    = lo_r + IW'(1);
      end
      qs_pkg::OP_CMP: begin
        if (status.is_less) begin
          // fetch the entry at the split point for the exchange
          tmp_nxt = mem_rd_r;
          mem_ra  = IW'(split_r);
        end else begin
          mem_ra = k_inc;
          if (!status.k_at_hi) begin
            k_nxt = k_inc;
          end
        end
      end
      qs_pkg::OP_SWAP_A: begin
        mem_we = 1'b1;
        mem_wa = k_r;
        mem_wd = mem_rd_r;
      end
      qs_pkg::OP_SWAP_B: begin
        mem_we    = 1'b1;
        mem_wa    = IW'(split_r);
        mem_wd    = tmp_r;
        split_nxt = split_r + ONE_C;
        mem_ra    = k_inc;
        if (!status.k_at_hi) begin
          k_nxt = k_inc;
        end
      end
      qs_pkg::OP_FIN: begin
        split_nxt = split_r - ONE_C;
        mem_ra    = IW'(split_r - ONE_C);
      end
      qs_pkg::OP_FIX_A: begin
        mem_we = 1'b1;
        mem_wa = lo_r;
        mem_wd = mem_rd_r;
      end
      qs_pkg::OP_FIX_B: begin
        // pivot lands at its final place, right part goes on the stack first
        mem_we = 1'b1;
        mem_wa = IW'(split_r);
        mem_wd = pivot_r;
        if (push_r_ok) begin
          stk_we  = 1'b1;
          stk_wd  = {IW'(split_r + ONE_C), hi_r};
          top_nxt = top_r + ONE_C;
        end
      end
      qs_pkg::OP_PUSH_L: begin
        if (push_l_ok) begin
          stk_we  = 1'b1;
          stk_wd  = {lo_r, IW'(split_r - ONE_C)};
          top_nxt = top_r + ONE_C;
        end
      end
      qs_pkg::OP_EMIT_INIT: begin
        k_nxt = '0;
      end
      qs_pkg::OP_EMIT_OUT: begin
        if (status.out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = mem_rd_r;
          out_last_nxt  = status.emit_last;
          out_ovf_nxt   = dropped_r;
          if (status.emit_last) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
          end else begin
            k_nxt = k_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      elem_mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= elem_mem[mem_ra];
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_r <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    k_r         <= k_nxt;
    split_r     <= split_nxt;
    pivot_r     <= pivot_nxt;
    tmp_r       <= tmp_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule

`default_nettype wire

// ===== rtl/core/qs_ctrl.sv =====
// ----------------------------------------------------------------------------
// qs_ctrl
// Sequencer for loading, partitioning and emission. Issues one datapath
// operation per cycle and branches on the datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module qs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_last_item,
  output logic                    in_ready,
  input  wire qs_pkg::dp_status_t status,
  output qs_pkg::dp_op_t          op
);

  qs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qs_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = qs_pkg::OP_IDLE;
    in_ready  = 1'b0;
    unique case (state_r)
      qs_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = qs_pkg::OP_LOAD;
          if (in_last_item) begin
            state_nxt = qs_pkg::ST_START;
          end
        end
      end
      qs_pkg::ST_START: begin
        op        = qs_pkg::OP_START;
        state_nxt = qs_pkg::ST_POP;
      end
      qs_pkg::ST_POP: begin
        if (status.top_zero) begin
          op        = qs_pkg::OP_EMIT_INIT;
          state_nxt = qs_pkg::ST_EMIT_RD;
        end else begin
          op        = qs_pkg::OP_POP;
          state_nxt = qs_pkg::ST_RANGE;
        end
      end
      qs_pkg::ST_RANGE: begin
        op        = qs_pkg::OP_RANGE;
        state_nxt = status.range_empty ? qs_pkg::ST_POP : qs_pkg::ST_PIVOT;
      end
      qs_pkg::ST_PIVOT: begin
        op        = qs_pkg::OP_PIVOT;
        state_nxt = qs_pkg::ST_CMP;
      end
      qs_pkg::ST_CMP: begin
        op = qs_pkg::OP_CMP;
        if (status.is_less) begin
          state_nxt = qs_pkg::ST_SWAP_A;
        end else if (status.k_at_hi) begin
          state_nxt = qs_pkg::ST_FIN;
        end
      end
      qs_pkg::ST_SWAP_A: begin
        op        = qs_pkg::OP_SWAP_A;
        state_nxt = qs_pkg::ST_SWAP_B;
      end
      qs_pkg::ST_SWAP_B: begin
        op        = qs_pkg::OP_SWAP_B;
        state_nxt = status.k_at_hi ? qs_pkg::ST_FIN : qs_pkg::ST_CMP;
      end
      qs_pkg::ST_FIN: begin
        op        = qs_pkg::OP_FIN;
        state_nxt = qs_pkg::ST_FIX_A;
      end
      qs_pkg::ST_FIX_A: begin
        op        = qs_pkg::OP_FIX_A;
        state_nxt = qs_pkg::ST_FIX_B;
      end
      qs_pkg::ST_FIX_B: begin
        op        = qs_pkg::OP_FIX_B;
        state_nxt = qs_pkg::ST_PUSH_L;
      end
      qs_pkg::ST_PUSH_L: begin
        op        = qs_pkg::OP_PUSH_L;
        state_nxt = qs_pkg::ST_POP;
      end
      qs_pkg::ST_EMIT_RD: begin
        state_nxt = qs_pkg::ST_EMIT_OUT;
      end
      qs_pkg::ST_EMIT_OUT: begin
        op = qs_pkg::OP_EMIT_OUT;
        if (status.out_free) begin
          state_nxt = status.emit_last ? qs_pkg::ST_LOAD : qs_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = qs_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/tb_quicksort_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quicksort_engine
// Feeds sets of signed values into the sort engine and compares every sorted
// beat against an ascending sort of the same set, including the overflow flag
// raised when a set runs past the store capacity.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [31:0] value;
  logic               last;
  logic               ovf;
} sorted_beat_t;

class sort_scoreboard;
  logic signed [31:0] loaded[$];
  bit                 dropped;
  sorted_beat_t       sorted_q[$];
  int                 errors;

  // appends one input beat; a closing beat turns the set into expected output
  function void note_input(logic signed [31:0] value, logic last);
    logic signed [31:0] vals[$];
    logic signed [31:0] t;
    sorted_beat_t       beat;
    int                 i;
    int                 j;
    if (loaded.size() < qs_pkg::DEPTH_DEF) begin
      loaded.push_back(value);
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    vals = loaded;
    for (i = 1; i < vals.size(); i++) begin
      t = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > t) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = t;
    end
    for (i = 0; i < vals.size(); i++) begin
      beat.value = vals[i];
      beat.last  = (i == vals.size() - 1);
      beat.ovf   = dropped;
      sorted_q.push_back(beat);
    end
    loaded.delete();
    dropped = 1'b0;
  endfunction

  function void check_result(logic signed [31:0] value, logic last, logic ovf);
    sorted_beat_t want;
    if (sorted_q.size() == 0) begin
      $error("unexpected beat: sorted_value %0d last_out %0b overflow %0b", value, last, ovf);
      errors++;
      return;
    end
    want = sorted_q.pop_front();
    if (value !== want.value) begin
      $error("sorted_value: expected %0d, got %0d", want.value, value);
      errors++;
    end
    if (last !== want.last) begin
      $error("last_out: expected %0b, got %0b", want.last, last);
      errors++;
    end
    if (ovf !== want.ovf) begin
      $error("overflow: expected %0b, got %0b", want.ovf, ovf);
      errors++;
    end
  endfunction

  function int pending();
    return sorted_q.size();
  endfunction
endclass

module tb_quicksort_engine;

  typedef enum int {
    PAT_RANDOM,
    PAT_NARROW,
    PAT_RISING,
    PAT_FALLING,
    PAT_EXTREMES
  } value_pattern_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic signed [31:0] in_value     = '0;
  logic               in_last_item = 1'b0;
  logic               out_ready    = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic signed [31:0] out_sorted_value;
  logic               out_last_out;
  logic               out_overflow;

  bit             idle_en = 1'b1;
  int             sent    = 0;
  sort_scoreboard sb;

  always #5 clk = ~clk;

  quicksort_engine DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_sorted_value, out_last_out, out_overflow);
    end
    out_ready <= !idle_en || ($urandom_range(99) >= 13);
  end

  task send_beat(input logic signed [31:0] v, input logic l);
    while (idle_en && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_value     <= v;
    in_last_item <= l;
    do @(posedge clk); while (!in_ready);
    sb.note_input(v, l);
    sent++;
  endtask

  task send_set(input int n, input value_pattern_t pat);
    logic signed [31:0] base;
    logic signed [31:0] v;
    int                 step;
    int                 i;
    base = $urandom_range(2000) - 1000;
    step = $urandom_range(3);
    for (i = 0; i < n; i++) begin
      case (pat)
        PAT_RANDOM:  v = $urandom;
        PAT_NARROW:  v = $urandom_range(7) - 4;
        PAT_RISING:  v = base + i * step;
        PAT_FALLING: v = base - i * step;
        default: begin
          case ($urandom_range(4))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7FFF_FFFF;
            2:       v = 0;
            3:       v = -1;
            default: v = 1;
          endcase
        end
      endcase
      send_beat(v, i == n - 1);
    end
  endtask

  initial begin
    int n;
    int pick;
    sb = new;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single-element sets at both ends of the range, then both ends with 0 and -1
    send_beat(32'sh7FFF_FFFF, 1'b1);
    send_beat(32'sh8000_0000, 1'b1);
    send_beat(32'sh7FFF_FFFF, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(0, 1'b0);
    send_beat(-1, 1'b1);
    // all equal to the pivot
    send_beat(5, 1'b0);
    send_beat(5, 1'b0);
    send_beat(5, 1'b0);
    send_beat(5, 1'b1);
    // reversed and already ordered
    send_beat(4, 1'b0);
    send_beat(3, 1'b0);
    send_beat(2, 1'b0);
    send_beat(1, 1'b1);
    send_beat(-2, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(1, 1'b0);
    send_beat(2, 1'b1);
    send_beat(1, 1'b0);
    send_beat(-1, 1'b1);

    // exactly full, closing beat dropped, and well past capacity
    send_set(qs_pkg::DEPTH_DEF, PAT_RISING);
    send_set(qs_pkg::DEPTH_DEF + 1, PAT_RANDOM);
    send_set(qs_pkg::DEPTH_DEF + 6, PAT_NARROW);

    while (sent < 480) begin
      idle_en = !(sent >= 260 && sent < 340);
      pick = $urandom_range(99);
      if (pick < 85)      n = $urandom_range(12, 1);
      else if (pick < 95) n = $urandom_range(40, 13);
      else                n = $urandom_range(qs_pkg::DEPTH_DEF + 4, qs_pkg::DEPTH_DEF);
      send_set(n, value_pattern_t'($urandom_range(4)));
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
